[hdl/isd_pkg.sv]
// ----------------------------------------------------------------------------
// isd_pkg: shared types and constants of the settle detector
// widths, request and class codes, register indexes and the per-id record
// ----------------------------------------------------------------------------
`default_nettype none

package isd_pkg;

  localparam int ID_COUNT = 256;
  localparam int ID_W     = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;

  localparam int KIND_W   = 2;
  localparam int MID_W    = 8;
  localparam int POS_W    = 16;
  localparam int CLS_W    = 2;
  localparam int HIT_W    = 8;
  localparam int TIME_W   = 32;
  localparam int TOL_W    = 16;
  localparam int TMO_W    = 16;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 16;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_SET  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OBS  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

  // settle classes
  localparam logic [CLS_W-1:0] CLASS_WAIT    = 2'd0;
  localparam logic [CLS_W-1:0] CLASS_GOAL    = 2'd1;
  localparam logic [CLS_W-1:0] CLASS_TIMEOUT = 2'd2;
  localparam logic [CLS_W-1:0] CLASS_NONE    = 2'd3;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] REG_ERROR_TOLERANCE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_HITS_NEEDED     = 2'd1;
  localparam logic [CFG_AW-1:0] REG_TIMEOUT_TICKS   = 2'd2;

  localparam logic [TOL_W-1:0] TOL_RESET  = 16'd10;
  localparam logic [HIT_W-1:0] HITS_RESET = 8'd3;
  localparam logic [TMO_W-1:0] TMO_RESET  = 16'd1000;

  localparam logic [HIT_W-1:0] HIT_MAX = '1;

  // per-id record kept in memory
  typedef struct packed {
    logic [POS_W-1:0]  target;
    logic [TIME_W-1:0] deadline;
    logic [HIT_W-1:0]  hit_count;
    logic [CLS_W-1:0]  last_class;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

endpackage

`default_nettype wire

[hdl/isd_in_if.sv]
// ----------------------------------------------------------------------------
// isd_in_if: request channel
// set-target, observation and tick requests with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface isd_in_if;
  logic                            valid;
  logic                            ready;
  logic [isd_pkg::KIND_W-1:0]      kind;
  logic [isd_pkg::MID_W-1:0]       motor_id;
  logic [isd_pkg::POS_W-1:0]       position_value;

  modport source (output valid, output kind, output motor_id, output position_value,
                  input ready);
  modport sink   (input valid, input kind, input motor_id, input position_value,
                  output ready);
endinterface

`default_nettype wire

[hdl/isd_out_if.sv]
// ----------------------------------------------------------------------------
// isd_out_if: event channel
// settle class change events with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface isd_out_if;
  logic                         valid;
  logic                         ready;
  logic [isd_pkg::MID_W-1:0]    event_id;
  logic [isd_pkg::CLS_W-1:0]    settle_state;
  logic [isd_pkg::POS_W-1:0]    abs_error;

  modport source (output valid, output event_id, output settle_state, output abs_error,
                  input ready);
  modport sink   (input valid, input event_id, input settle_state, input abs_error,
                  output ready);
endinterface

`default_nettype wire

[hdl/isd_cfg_if.sv]
// ----------------------------------------------------------------------------
// isd_cfg_if: configuration write channel
// register index and write data with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface isd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [isd_pkg::CFG_AW-1:0]    addr;
  logic [isd_pkg::CFG_DW-1:0]    data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

[hdl/isd_ram.sv]
// ----------------------------------------------------------------------------
// isd_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module isd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/in_position_settle_detector.sv]
// ----------------------------------------------------------------------------
// in_position_settle_detector: per-motor settle detection with timeout
// keeps target, deadline, hit run and last class per motor id in one ram,
// classifies each observation and reports class changes as events
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   in_req    in    valid/ready    kind, motor_id, position_value
//   out_evt   out   valid/ready    event_id, settle_state, abs_error
//   cfg_wr    in    valid/ready    addr, data (always ready)
//
// a tick or an ignored request is handled at acceptance, a set-target or an
// observation of a known id goes through the ram read, then the
// modify and write-back of the same record
// reset (rst_n low, synchronous) clears the valid bits, time and registers
// requests are held off while an undelivered event would block the
// event register at the end of the write-back cycle
// ----------------------------------------------------------------------------
`default_nettype none

module in_position_settle_detector (
  input  wire logic    clk,
  input  wire logic    rst_n,
  isd_in_if.sink       in_req,
  isd_out_if.source    out_evt,
  isd_cfg_if.sink      cfg_wr
);

  // configuration registers
  logic [isd_pkg::TOL_W-1:0]  error_tolerance_r;
  logic [isd_pkg::HIT_W-1:0]  hits_needed_r;
  logic [isd_pkg::TMO_W-1:0]  timeout_ticks_r;

  // control
  isd_pkg::state_t            state_r, state_nxt;
  logic [isd_pkg::TIME_W-1:0] time_now_r;
  logic [isd_pkg::ID_COUNT-1:0] entry_valid_r;

  // request held for the write-back cycle
  logic                       op_set_r;
  logic                       op_prev_valid_r;
  logic [isd_pkg::MID_W-1:0]  op_id_r;
  logic [isd_pkg::POS_W-1:0]  op_pos_r;

  // event register
  logic                       out_valid_r, out_valid_nxt;
  logic [isd_pkg::MID_W-1:0]  out_id_r;
  logic [isd_pkg::CLS_W-1:0]  out_cls_r;
  logic [isd_pkg::POS_W-1:0]  out_err_r;

  // ram side
  logic                       ram_we;
  logic [isd_pkg::ID_W-1:0]   ram_raddr, ram_waddr, in_addr;
  logic [isd_pkg::ENTRY_W-1:0] ram_rdata, ram_wdata;
  isd_pkg::entry_t            rd_entry, wr_entry;

  // datapath
  logic                       in_accept, id_in_range, in_known, start_op;
  logic [isd_pkg::POS_W-1:0]  abs_err;
  logic [isd_pkg::HIT_W-1:0]  hit_new;
  logic [isd_pkg::TIME_W-1:0] since_deadline;
  logic                       past_deadline;
  logic [isd_pkg::CLS_W-1:0]  cls_new;
  logic                       emit;

  // handshakes
  assign cfg_wr.ready  = 1'b1;
  assign in_req.ready  = (state_r == isd_pkg::ST_IDLE) && (!out_valid_r || out_evt.ready);
  assign in_accept     = in_req.valid && in_req.ready;

  assign out_evt.valid        = out_valid_r;
  assign out_evt.event_id     = out_id_r;
  assign out_evt.settle_state = out_cls_r;
  assign out_evt.abs_error    = out_err_r;

  // id decode
  assign id_in_range = (32'(in_req.motor_id) < isd_pkg::ID_COUNT);
  assign in_addr     = in_req.motor_id[isd_pkg::ID_W-1:0];
  assign in_known    = entry_valid_r[in_addr];

  // a set-target always rewrites the record, an observation only for a known id
  always_comb begin
    start_op = 1'b0;
    if (in_accept && id_in_range) begin
      unique case (in_req.kind)
        isd_pkg::KIND_SET: start_op = 1'b1;
        isd_pkg::KIND_OBS: start_op = in_known;
        default:           start_op = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      isd_pkg::ST_IDLE: if (start_op) state_nxt = isd_pkg::ST_EXEC;
      isd_pkg::ST_EXEC: state_nxt = isd_pkg::ST_IDLE;
      default:          state_nxt = isd_pkg::ST_IDLE;
    endcase
  end

  // record read is issued at acceptance, data arrives in the write-back cycle
  assign ram_raddr = in_addr;
  assign ram_waddr = op_id_r[isd_pkg::ID_W-1:0];
  assign rd_entry  = isd_pkg::entry_t'(ram_rdata);

  isd_ram #(
    .WIDTH (isd_pkg::ENTRY_W),
    .DEPTH (isd_pkg::ID_COUNT)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // observation arithmetic
  assign abs_err = (op_pos_r >= rd_entry.target) ? (op_pos_r - rd_entry.target)
                                                 : (rd_entry.target - op_pos_r);

  always_comb begin
    if (abs_err <= error_tolerance_r) begin
      hit_new = (rd_entry.hit_count == isd_pkg::HIT_MAX) ? rd_entry.hit_count
                                                         : rd_entry.hit_count + 1'b1;
    end else begin
      hit_new = '0;
    end
  end

  // past the deadline when the wrapped difference is positive and below half range
  assign since_deadline = time_now_r - rd_entry.deadline;
  assign past_deadline  = (since_deadline != '0) && !since_deadline[isd_pkg::TIME_W-1];

  always_comb begin
    if (hit_new >= hits_needed_r) begin
      cls_new = isd_pkg::CLASS_GOAL;
    end else if (past_deadline) begin
      cls_new = isd_pkg::CLASS_TIMEOUT;
    end else begin
      cls_new = isd_pkg::CLASS_WAIT;
    end
  end

  // write-back record
  always_comb begin
    if (op_set_r) begin
      wr_entry.target     = op_pos_r;
      wr_entry.deadline   = time_now_r + isd_pkg::TIME_W'(timeout_ticks_r);
      wr_entry.hit_count  = '0;
      // a fresh id has never reported, a repeated command keeps its class
      wr_entry.last_class = op_prev_valid_r ? rd_entry.last_class : isd_pkg::CLASS_NONE;
    end else begin
      wr_entry.target     = rd_entry.target;
      wr_entry.deadline   = rd_entry.deadline;
      wr_entry.hit_count  = hit_new;
      wr_entry.last_class = cls_new;
    end
  end

  assign ram_we    = (state_r == isd_pkg::ST_EXEC);
  assign ram_wdata = wr_entry;

  // events only on a class change of an observation
  assign emit = (state_r == isd_pkg::ST_EXEC) && !op_set_r
                && (cls_new != rd_entry.last_class);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_evt.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= isd_pkg::ST_IDLE;
      time_now_r    <= '0;
      entry_valid_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_accept && (in_req.kind == isd_pkg::KIND_TICK)) begin
        time_now_r <= time_now_r + 1'b1;
      end
      if (in_accept && id_in_range && (in_req.kind == isd_pkg::KIND_SET)) begin
        entry_valid_r[in_addr] <= 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_tolerance_r <= isd_pkg::TOL_RESET;
      hits_needed_r     <= isd_pkg::HITS_RESET;
      timeout_ticks_r   <= isd_pkg::TMO_RESET;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      unique case (cfg_wr.addr)
        isd_pkg::REG_ERROR_TOLERANCE: error_tolerance_r <= cfg_wr.data[isd_pkg::TOL_W-1:0];
        isd_pkg::REG_HITS_NEEDED:     hits_needed_r     <= cfg_wr.data[isd_pkg::HIT_W-1:0];
        isd_pkg::REG_TIMEOUT_TICKS:   timeout_ticks_r   <= cfg_wr.data[isd_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start_op) begin
      op_set_r        <= (in_req.kind == isd_pkg::KIND_SET);
      op_prev_valid_r <= in_known;
      op_id_r         <= in_req.motor_id;
      op_pos_r        <= in_req.position_value;
    end
    if (emit) begin
      out_id_r  <= op_id_r;
      out_cls_r <= cls_new;
      out_err_r <= abs_err;
    end
  end

`ifndef SYNTHESIS
  // the write-back state is always followed by idle
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isd_pkg::ST_EXEC) |=> (state_r == isd_pkg::ST_IDLE))
    else $error("write-back cycle did not return to idle");

  // no request is taken while a record is being written back
  a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isd_pkg::ST_EXEC) |-> !in_accept)
    else $error("request accepted during write-back");

  // the event register is free whenever a write-back may load it
  a_event_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isd_pkg::ST_EXEC) |-> (!out_valid_r || out_evt.ready))
    else $error("event register busy during write-back");

  // an event only appears after a write-back of an observation
  a_event_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == isd_pkg::ST_EXEC && !op_set_r))
    else $error("event raised without an observation write-back");

  // an emitted event always belongs to a known id
  a_event_known: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> entry_valid_r[ram_waddr])
    else $error("event for an id without a target");
`endif

endmodule

`default_nettype wire

[dv/in_position_settle_detector_tb.sv]
// ----------------------------------------------------------------------------
// in_position_settle_detector_tb: self-checking bench for the settle detector
// drives set-target, observation, tick and unused requests with random gaps,
// predicts every class-change event in a scoreboard and compares it field by
// field with the event channel, across several register settings
// ----------------------------------------------------------------------------

module in_position_settle_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // kind 3 has no meaning in the block, used as noise
  localparam logic [isd_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int unsigned SETTLE_CYCLES = 8;     // read and write-back pipe plus event register, with margin
  localparam int unsigned DRAIN_GUARD   = 4000;  // cycles allowed for outstanding events
  localparam int unsigned HOLD_CYCLES   = 400;   // long receiver hold-off

  typedef struct packed {
    logic [isd_pkg::MID_W-1:0] id;
    logic [isd_pkg::CLS_W-1:0] cls;
    logic [isd_pkg::POS_W-1:0] err;
  } settle_event_t;

  // predicts class-change events and checks the event stream against them
  class settle_scoreboard;
    logic [isd_pkg::TOL_W-1:0]  tol;
    logic [isd_pkg::HIT_W-1:0]  hits_req;
    logic [isd_pkg::TMO_W-1:0]  tmo;
    bit                         known     [isd_pkg::ID_COUNT];
    logic [isd_pkg::POS_W-1:0]  target    [isd_pkg::ID_COUNT];
    logic [isd_pkg::TIME_W-1:0] deadline  [isd_pkg::ID_COUNT];
    logic [isd_pkg::HIT_W-1:0]  run_len   [isd_pkg::ID_COUNT];
    logic [isd_pkg::CLS_W-1:0]  last_cls  [isd_pkg::ID_COUNT];
    logic [isd_pkg::TIME_W-1:0] now;
    settle_event_t              pending[$];
    int unsigned                failures;
    int unsigned                kind_count[4];
    int unsigned                class_count[4];

    function new();
      tol      = isd_pkg::TOL_RESET;
      hits_req = isd_pkg::HITS_RESET;
      tmo      = isd_pkg::TMO_RESET;
      now      = '0;
      failures = 0;
      for (int i = 0; i < isd_pkg::ID_COUNT; i++) begin
        known[i]    = 1'b0;
        target[i]   = '0;
        deadline[i] = '0;
        run_len[i]  = '0;
        last_cls[i] = isd_pkg::CLASS_NONE;
      end
      for (int i = 0; i < 4; i++) begin
        kind_count[i]  = 0;
        class_count[i] = 0;
      end
    endfunction

    function void set_register(logic [isd_pkg::CFG_AW-1:0] addr,
                               logic [isd_pkg::CFG_DW-1:0] value);
      case (addr)
        isd_pkg::REG_ERROR_TOLERANCE: tol      = value[isd_pkg::TOL_W-1:0];
        isd_pkg::REG_HITS_NEEDED:     hits_req = value[isd_pkg::HIT_W-1:0];
        isd_pkg::REG_TIMEOUT_TICKS:   tmo      = value[isd_pkg::TMO_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [isd_pkg::KIND_W-1:0] kind,
                               logic [isd_pkg::MID_W-1:0] id,
                               logic [isd_pkg::POS_W-1:0] pos);
      logic [isd_pkg::POS_W-1:0]  err;
      logic [isd_pkg::CLS_W-1:0]  cls;
      logic [isd_pkg::TIME_W-1:0] lag;
      settle_event_t              ev;
      kind_count[kind]++;
      case (kind)
        isd_pkg::KIND_TICK: now = now + 1'b1;
        isd_pkg::KIND_SET: begin
          if (int'(id) < isd_pkg::ID_COUNT) begin
            known[id]    = 1'b1;
            target[id]   = pos;
            deadline[id] = now + isd_pkg::TIME_W'(tmo);
            run_len[id]  = '0;
          end
        end
        isd_pkg::KIND_OBS: begin
          if (int'(id) < isd_pkg::ID_COUNT && known[id]) begin
            err = (pos >= target[id]) ? pos - target[id] : target[id] - pos;
            if (err <= tol) begin
              if (run_len[id] != isd_pkg::HIT_MAX) run_len[id] = run_len[id] + 1'b1;
            end else begin
              run_len[id] = '0;
            end
            // past the deadline: wrapped difference in 1 .. 2^31-1
            lag = now - deadline[id];
            if (run_len[id] >= hits_req)
              cls = isd_pkg::CLASS_GOAL;
            else if (lag != '0 && !lag[isd_pkg::TIME_W-1])
              cls = isd_pkg::CLASS_TIMEOUT;
            else
              cls = isd_pkg::CLASS_WAIT;
            if (cls != last_cls[id]) begin
              last_cls[id] = cls;
              ev.id  = id;
              ev.cls = cls;
              ev.err = err;
              pending.push_back(ev);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_event(logic [isd_pkg::MID_W-1:0] id,
                              logic [isd_pkg::CLS_W-1:0] cls,
                              logic [isd_pkg::POS_W-1:0] err);
      settle_event_t want;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected event id %0d state %0d err %0d", $time, id, cls, err);
        return;
      end
      want = pending.pop_front();
      class_count[want.cls]++;
      if (id !== want.id || cls !== want.cls || err !== want.err) begin
        failures++;
        if (failures <= 10)
          $display("%0t: event differs, expected id %0d state %0d err %0d, %s %0d %s %0d %s %0d",
                   $time, want.id, want.cls, want.err, "got id", id, "state", cls,
                   "err", err);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  isd_in_if  in_req ();
  isd_out_if out_evt ();
  isd_cfg_if cfg_wr ();

  in_position_settle_detector u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req.sink),
    .out_evt (out_evt.source),
    .cfg_wr  (cfg_wr.sink)
  );

  settle_scoreboard sb;

  // last target sent per id, used to aim observations near it
  logic [isd_pkg::POS_W-1:0] aim_pos [isd_pkg::ID_COUNT];

  bit          sender_gaps_on;
  bit          sink_stalls_on;
  int unsigned hold_requests;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // event receiver: random stall after each event, one long hold-off on demand
  initial begin : event_sink
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned holds_done;
    stall_left = 0;
    hold_left  = 0;
    holds_done = 0;
    out_evt.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_evt.valid && out_evt.ready) begin
        sb.check_event(out_evt.event_id, out_evt.settle_state, out_evt.abs_error);
        stall_left = sink_stalls_on ? $urandom_range(0, 15) : 0;
      end
      if (hold_requests != holds_done) begin
        holds_done = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (!rst_n) begin
        out_evt.ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_evt.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_evt.ready <= 1'b0;
        stall_left--;
      end else begin
        out_evt.ready <= 1'b1;
      end
    end
  end

  // one request, preceded by a random gap; valid is left high after acceptance
  task automatic send_request(logic [isd_pkg::KIND_W-1:0] kind,
                              logic [isd_pkg::MID_W-1:0] id,
                              logic [isd_pkg::POS_W-1:0] pos);
    int unsigned gap;
    gap = sender_gaps_on ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid          <= 1'b1;
    in_req.kind           <= kind;
    in_req.motor_id       <= id;
    in_req.position_value <= pos;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    if (kind == isd_pkg::KIND_SET) aim_pos[id] = pos;
    sb.note_request(kind, id, pos);
  endtask

  // stop offering, then wait for all predicted events and for the pipe to empty
  task automatic wait_idle();
    int unsigned guard;
    in_req.valid <= 1'b0;
    guard = 0;
    while (sb.pending.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [isd_pkg::CFG_AW-1:0] addr,
                                logic [isd_pkg::CFG_DW-1:0] value);
    cfg_wr.valid <= 1'b1;
    cfg_wr.addr  <= addr;
    cfg_wr.data  <= value;
    @(posedge clk);
    while (!cfg_wr.ready) @(posedge clk);
    sb.set_register(addr, value);
  endtask

  // only called with the block idle
  task automatic apply_settings(logic [isd_pkg::TOL_W-1:0] tol,
                                logic [isd_pkg::HIT_W-1:0] hits,
                                logic [isd_pkg::TMO_W-1:0] tmo);
    write_register(isd_pkg::REG_ERROR_TOLERANCE, isd_pkg::CFG_DW'(tol));
    write_register(isd_pkg::REG_HITS_NEEDED, isd_pkg::CFG_DW'(hits));
    write_register(isd_pkg::REG_TIMEOUT_TICKS, isd_pkg::CFG_DW'(tmo));
    cfg_wr.valid <= 1'b0;
  endtask

  // well-formed traffic on a small id pool, with some stray ids and noise
  task automatic run_random(int unsigned count, int unsigned id_span);
    int unsigned                roll;
    int unsigned                reach;
    logic [isd_pkg::KIND_W-1:0] kind;
    logic [isd_pkg::MID_W-1:0]  id;
    logic [isd_pkg::POS_W-1:0]  pos;
    logic [isd_pkg::POS_W-1:0]  delta;
    reach = int'(sb.tol) + 3;
    if (reach > 65535) reach = 65535;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      id   = ($urandom_range(0, 9) == 0) ? isd_pkg::MID_W'($urandom)
                                         : isd_pkg::MID_W'($urandom_range(0, id_span - 1));
      pos  = isd_pkg::POS_W'($urandom);
      if (roll < 12) begin
        kind = isd_pkg::KIND_SET;
      end else if (roll < 72) begin
        kind = isd_pkg::KIND_OBS;
        // mostly near the target so hit runs build up, sometimes anywhere
        if ($urandom_range(0, 4) != 0) begin
          delta = isd_pkg::POS_W'($urandom_range(0, reach));
          pos   = $urandom_range(0, 1) ? aim_pos[id] + delta : aim_pos[id] - delta;
        end
      end else if (roll < 95) begin
        kind = isd_pkg::KIND_TICK;
      end else begin
        kind = KIND_UNUSED;
      end
      send_request(kind, id, pos);
    end
  endtask

  initial begin : stimulus
    int unsigned leftover;
    sb = new();
    for (int i = 0; i < isd_pkg::ID_COUNT; i++) aim_pos[i] = '0;
    sender_gaps_on = 1'b1;
    sink_stalls_on <= 1'b1;
    hold_requests  <= 0;

    rst_n                 <= 1'b0;
    in_req.valid          <= 1'b0;
    in_req.kind           <= isd_pkg::KIND_TICK;
    in_req.motor_id       <= '0;
    in_req.position_value <= '0;
    cfg_wr.valid          <= 1'b0;
    cfg_wr.addr           <= isd_pkg::REG_ERROR_TOLERANCE;
    cfg_wr.data           <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on reset settings: tolerance 10, three hits, 1000 ticks
    send_request(isd_pkg::KIND_OBS, 8'd200, 16'h1234);     // unknown id, no event
    send_request(KIND_UNUSED, 8'hFF, 16'hFFFF);            // unused kind, ignored
    send_request(isd_pkg::KIND_SET, 8'd0, 16'h0000);
    send_request(isd_pkg::KIND_OBS, 8'd0, 16'h0000);       // first report, wait
    send_request(isd_pkg::KIND_OBS, 8'd0, 16'd10);         // error on the tolerance edge
    send_request(isd_pkg::KIND_OBS, 8'd0, 16'h0000);       // third hit, goal
    send_request(isd_pkg::KIND_OBS, 8'd0, 16'd11);         // just outside, back to wait
    send_request(isd_pkg::KIND_SET, 8'd255, 16'hFFFF);
    send_request(isd_pkg::KIND_OBS, 8'd255, 16'h0000);     // largest error
    send_request(isd_pkg::KIND_SET, 8'd0, 16'd100);        // repeated command keeps last class
    send_request(isd_pkg::KIND_OBS, 8'd0, 16'd100);
    send_request(isd_pkg::KIND_TICK, 8'hAA, 16'h5555);
    send_request(isd_pkg::KIND_TICK, 8'h55, 16'hAAAA);
    send_request(isd_pkg::KIND_OBS, 8'd255, 16'hFFFF);
    send_request(isd_pkg::KIND_OBS, 8'd255, 16'hFFFF);
    send_request(isd_pkg::KIND_OBS, 8'd255, 16'hFFFF);     // goal from the far end
    wait_idle();

    // zero tolerance, zero hits: every known observation is goal
    apply_settings(16'd0, 8'd0, 16'd0);
    send_request(isd_pkg::KIND_SET, 8'd5, 16'd1234);
    send_request(isd_pkg::KIND_OBS, 8'd5, 16'd4321);
    send_request(isd_pkg::KIND_TICK, 8'd0, 16'd0);
    send_request(isd_pkg::KIND_OBS, 8'd5, 16'd1234);
    run_random(40, 8);
    wait_idle();

    // short deadline so timeouts show up, receiver without stalls
    sink_stalls_on <= 1'b0;
    apply_settings(16'd5, 8'd2, 16'd4);
    run_random(80, 4);
    wait_idle();

    // widest settings: all observations hit, run length saturates past the goal
    sink_stalls_on <= 1'b1;
    sender_gaps_on = 1'b0;
    apply_settings(16'hFFFF, 8'hFF, 16'hFFFF);
    send_request(isd_pkg::KIND_SET, 8'd7, isd_pkg::POS_W'($urandom));
    repeat (258) send_request(isd_pkg::KIND_OBS, 8'd7, isd_pkg::POS_W'($urandom));
    send_request(isd_pkg::KIND_OBS, 8'd7, 16'h8000);
    wait_idle();

    // back-to-back requests while the receiver holds off for a long stretch
    apply_settings(16'd20, 8'd1, 16'd10);
    hold_requests <= hold_requests + 1;
    run_random(80, 6);
    wait_idle();

    // random settings to finish, gaps on both sides again
    sender_gaps_on = 1'b1;
    apply_settings(isd_pkg::TOL_W'($urandom_range(0, 64)),
                   isd_pkg::HIT_W'($urandom_range(0, 6)),
                   isd_pkg::TMO_W'($urandom_range(0, 30)));
    run_random(60, 8);
    wait_idle();

    leftover = sb.pending.size();
    if (leftover != 0)
      $display("%0d predicted events never arrived", leftover);
    sb.failures += leftover;

    $display("covered %0d set-target, %0d observation, %0d tick and %0d unused-kind requests",
             sb.kind_count[isd_pkg::KIND_SET], sb.kind_count[isd_pkg::KIND_OBS],
             sb.kind_count[isd_pkg::KIND_TICK], sb.kind_count[KIND_UNUSED]);
    $display("checked %0d wait, %0d goal and %0d timeout events, %0d failures",
             sb.class_count[isd_pkg::CLASS_WAIT], sb.class_count[isd_pkg::CLASS_GOAL],
             sb.class_count[isd_pkg::CLASS_TIMEOUT], sb.failures);
    if (sb.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
